// ----- rtl/rqps_pkg.sv -----
// shared types and codes for the ready queue policy selector
// no dependencies; imported by every module of the block
package rqps_pkg;

  localparam int SLOTS_DEF = 16;

  // configuration port
  localparam int          CFG_AW     = 3;
  localparam int          CFG_DW     = 32;
  localparam logic [2:0]  REG_POLICY = 3'd0;

  // scheduling policies
  localparam logic [2:0] POL_FIFO  = 3'd0;
  localparam logic [2:0] POL_SJF   = 3'd1;
  localparam logic [2:0] POL_SRTN  = 3'd2;
  localparam logic [2:0] POL_FAIR  = 3'd3;
  localparam logic [2:0] POL_PRIO  = 3'd4;

  // item kinds
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SELECT = 1'b1;

  // result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_SELECTED = 2'd2;
  localparam logic [1:0] ST_IDLE     = 2'd3;

  // one table entry, id in the lowest bits
  typedef struct packed {
    logic signed [15:0] prio;
    logic [15:0]        served;
    logic [15:0]        target;
    logic [7:0]         id;
  } slot_t;

endpackage

// ----- rtl/rqps_mem.sv -----
// ready table storage: one write port, one read port, registered read data
// depends on rqps_pkg for the entry type
module rqps_mem
  import rqps_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  slot_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output slot_t         rdata
);

  slot_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rqps_cmp.sv -----
// policy comparator: is the candidate entry strictly preferred over the best so far
// depends on rqps_pkg for the entry type and policy codes
module rqps_cmp
  import rqps_pkg::*;
(
  input  logic [2:0] policy,
  input  slot_t      cand,
  input  slot_t      best,
  output logic       better
);

  logic signed [16:0] rem_cand;
  logic signed [16:0] rem_best;
  logic [31:0]        lhs;
  logic [31:0]        rhs;

  always_comb begin
    rem_cand = $signed({1'b0, cand.target}) - $signed({1'b0, cand.served});
    rem_best = $signed({1'b0, best.target}) - $signed({1'b0, best.served});
    // exact ratio compare by cross products
    lhs = cand.served * best.target;
    rhs = best.served * cand.target;
    case (policy)
      POL_SJF:  better = cand.target < best.target;
      POL_SRTN: better = rem_cand < rem_best;
      POL_FAIR: better = lhs < rhs;
      POL_PRIO: better = cand.prio > best.prio;
      default:  better = 1'b0;
    endcase
  end

endmodule

// ----- rtl/ready_queue_policy_selector.sv -----
// top level of the ready queue policy selector: control sequencer, apb register, stream ports
// depends on rqps_pkg, rqps_mem and rqps_cmp
//
// The block keeps a ready table of up to SLOTS entries in arrival order in one
// single-port-read memory. An insert item (tuser 0) appends an entry and
// answers status inserted, or table full if all slots are taken. A select item
// (tuser 1) scans the table one entry per cycle, picks the entry that the
// policy register prefers (ties go to the oldest), returns its id and closes
// the gap by copying each later entry down one place, again one per cycle,
// since every step goes through the memory's one read port. An insert, or a
// select on an empty table (answered idle), goes from accept to the done state;
// a select on entries passes through scan and, unless the youngest is chosen,
// shift first. One item is in work at a time; the result sits in an output
// register and the next item may be taken while it waits. The user must write the
// policy register over the apb port only while idle; the block does not enforce it.
module ready_queue_policy_selector
  import rqps_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input items
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [55:0]       in_tdata,   // proc_id, target_time, served_time, prio
  input  logic [0:0]        in_tuser,   // action
  // result items
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // chosen_id, occupancy, zero pad
  output logic [1:0]        out_tuser,  // status
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]    policy_r, policy_nxt;
  logic [AW-1:0] k_r, k_nxt;           // scan position, then shift destination
  slot_t         best_r, best_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [7:0]    res_id_r, res_id_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [15:0]   out_tdata_r, out_tdata_nxt;
  logic [1:0]    out_tuser_r, out_tuser_nxt;

  // memory port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  slot_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  slot_t         mem_rdata;

  logic          cand_better;
  logic          take;
  slot_t         bsel;
  logic [AW-1:0] bidx;
  logic [CW-1:0] kx;
  logic [CW-1:0] last_idx;
  logic [CW-1:0] bidx_x;
  logic [CW-1:0] rd_next;
  logic [CW+4:0] cnt_ext;
  logic          in_acc;
  logic          cfg_wr;
  slot_t         in_slot;

  rqps_mem #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rqps_cmp u_cmp (
    .policy (policy_r),
    .cand   (mem_rdata),
    .best   (best_r),
    .better (cand_better)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // apb register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_POLICY) ? CFG_DW'(policy_r) : '0;

  // unpack the incoming item
  assign in_slot.id     = in_tdata[7:0];
  assign in_slot.target = in_tdata[23:8];
  assign in_slot.served = in_tdata[39:24];
  assign in_slot.prio   = $signed(in_tdata[55:40]);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    policy_nxt     = policy_r;
    k_nxt          = k_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    mem_we    = 1'b0;
    mem_waddr = k_r;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;

    kx       = CW'(k_r);
    last_idx = count_r - CW'(1);
    // first entry always seeds the best, later ones must be strictly better
    take     = (k_r == '0) || cand_better;
    bsel     = take ? mem_rdata : best_r;
    bidx     = take ? k_r : best_idx_r;
    bidx_x   = CW'(bidx);
    rd_next  = kx + CW'(1);
    cnt_ext  = (CW + 5)'(count_r);

    if (cfg_wr && (cfg_paddr == REG_POLICY)) begin
      policy_nxt = cfg_pwdata[2:0];
    end

    // result leaves when the consumer takes it
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_id_nxt = '0;
          state_nxt  = S_DONE;
          if (in_tuser[0] == ACT_INSERT) begin
            if (count_r == CW'(SLOTS)) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we         = 1'b1;
              mem_waddr      = count_r[AW-1:0];
              mem_wdata      = in_slot;
              count_nxt      = count_r + CW'(1);
              res_status_nxt = ST_INSERTED;
            end
          end else if (count_r == '0) begin
            res_status_nxt = ST_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            k_nxt     = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        best_nxt     = bsel;
        best_idx_nxt = bidx;
        if (kx == last_idx) begin
          res_status_nxt = ST_SELECTED;
          res_id_nxt     = bsel.id;
          if (bidx_x == last_idx) begin
            // youngest entry chosen, nothing to close up
            count_nxt = last_idx;
            state_nxt = S_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = bidx_x[AW-1:0] + AW'(1);
            k_nxt     = bidx;
            state_nxt = S_SHIFT;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_next[AW-1:0];
          k_nxt     = rd_next[AW-1:0];
        end
      end
      S_SHIFT: begin
        // entry k+1 arrives, store it one place down
        mem_we    = 1'b1;
        mem_waddr = k_r;
        mem_wdata = mem_rdata;
        if (rd_next == last_idx) begin
          count_nxt = last_idx;
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_next[AW-1:0] + AW'(1);
          k_nxt     = rd_next[AW-1:0];
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_status_r;
          out_tdata_nxt  = {3'b000, cnt_ext[4:0], res_id_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      policy_r     <= POL_FIFO;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      policy_r     <= policy_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    k_r          <= k_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  // table never holds more than its slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS))
    else $error("entry count above table size");

  // a scan only runs on a non-empty table and stays inside it
  a_scan_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (count_r != '0) && (CW'(k_r) < count_r))
    else $error("scan outside the valid entries");

  // best index never runs ahead of the scan position
  a_best_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && (k_r != '0) |-> best_idx_r < k_r)
    else $error("best index ahead of scan");

  // shift writes stay below the last live entry
  a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> mem_we && (CW'(mem_waddr) < last_idx))
    else $error("shift write beyond live entries");

  // a select that ends in the shift state takes exactly one entry out
  a_select_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) && (state_nxt == S_DONE) |=> count_r == $past(count_r) - CW'(1))
    else $error("select did not remove one entry");

endmodule
